[design/ssh_pkg.sv]
package ssh_pkg;

	localparam int HEAP_DEPTH_DEF = 32;
	localparam int CoordW = 31;

	typedef struct packed {
		logic              cmd;
		logic [CoordW-1:0] left_edge;
		logic [CoordW-1:0] right_edge;
		logic [CoordW-1:0] bldg_height;
		logic              next_same_left;
	} in_item_t;

	typedef struct packed {
		logic [CoordW-1:0] point_x;
		logic [CoordW-1:0] point_height;
		logic              run_last;
		logic              heap_overflow;
	} out_item_t;

	// input command codes
	localparam logic CMD_BLDG  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// source of an emitted key point
	typedef enum logic [1:0] {
		SRC_DROP,
		SRC_RISE,
		SRC_OVF
	} src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_SCAN_A,
		S_POP_RD,
		S_POP_WR,
		S_B_CHK,
		S_SCAN_B,
		S_DROP,
		S_INS,
		S_SCAN_C,
		S_RISE,
		S_OVF,
		S_FIN
	} state_t;

	typedef struct packed {
		logic ld;
		logic scan_start;
		logic scan_run;
		logic set_gone;
		logic pop_rd;
		logic pop_wr;
		logic ins;
		logic set_ovf;
		logic cur_best;
		logic cur_zero;
		logic emit;
		src_t src;
		logic fin;
	} ctl_cmd_t;

	typedef struct packed {
		logic flush;
		logic count_zero;
		logic count_full;
		logic scan_done;
		logic best_lt_left;
		logic best_le_gone;
		logic cur_lt_best;
		logic cur_lt_gone;
		logic same_next;
		logic ovf;
		logic emitted;
		logic pend_v;
		logic out_free;
	} ctl_sts_t;

endpackage

[design/skyline_sweep_heap_core.sv]
// A top-of-heap scan reads the heap store through its registered read port, one read per
// cycle. Each retired top and each entry it covers adds a pop and another scan.
// One item in work at a time; points leave through an output register, stalls hold it.
// Reset clears control, fill count and skyline height; the heap store is not cleared.
module skyline_sweep_heap_core
	import ssh_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bldg_valid,
	output logic      bldg_stall,
	input  in_item_t  bldg,
	output logic      point_valid,
	input  logic      point_stall,
	output out_item_t point
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ssh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.bldg_valid (bldg_valid),
		.bldg_stall (bldg_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	ssh_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.bldg        (bldg),
		.point_stall (point_stall),
		.point_valid (point_valid),
		.point       (point)
	);

	// an accepted item holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(bldg_valid && !bldg_stall) |=> bldg_stall)
		else $error("input taken while item in work");

	// a point is pushed only when the held point can move on
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!sts.pend_v || sts.out_free))
		else $error("point emitted without room");

	// no pop from an empty heap
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_wr |-> !sts.count_zero)
		else $error("pop from empty heap");

	// no insert into a full heap
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> !sts.count_full)
		else $error("insert into full heap");

endmodule

[design/ssh_dp.sv]
module ssh_dp
	import ssh_pkg::*;
#(
	parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_cmd_t  cmd,
	output ctl_sts_t  sts,
	input  in_item_t  bldg,
	input  logic      point_stall,
	output logic      point_valid,
	output out_item_t point
);

	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int IW = $clog2(HEAP_DEPTH);
	localparam int EW = 2 * CoordW;

	// heap store: {height, right edge}
	logic [EW-1:0] mem [HEAP_DEPTH];
	logic [EW-1:0] rdata_q;

	in_item_t          in_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic              rd_v_s1;
	logic [IW-1:0]     rd_i_s1;
	logic [CoordW-1:0] best_h_q, best_r_q;
	logic [IW-1:0]     best_i_q;
	logic              best_v_q;
	logic [CoordW-1:0] cur_q, gone_h_q, gone_r_q;
	logic              ovf_q, emitted_q;
	logic              pend_v_q;
	out_item_t         pend_q;
	logic              out_v_q;
	out_item_t         out_q;

	logic              idx_lt;
	logic              rd_en;
	logic [IW-1:0]     raddr;
	logic              we;
	logic [IW-1:0]     waddr;
	logic [EW-1:0]     wdata;
	logic [CoordW-1:0] rd_h, rd_r;
	logic              rd_gt;
	logic              out_free;
	out_item_t         new_pt;

	assign idx_lt = idx_q < count_q;
	assign rd_en  = cmd.pop_rd | (cmd.scan_run & idx_lt);
	assign raddr  = cmd.pop_rd ? IW'(count_q - 1'b1) : idx_q[IW-1:0];
	assign we     = cmd.ins | cmd.pop_wr;
	assign waddr  = cmd.ins ? count_q[IW-1:0] : best_i_q;
	assign wdata  = cmd.ins ? {in_q.bldg_height, in_q.right_edge} : rdata_q;

	assign rd_h  = rdata_q[EW-1:CoordW];
	assign rd_r  = rdata_q[CoordW-1:0];
	assign rd_gt = (rd_h > best_h_q) || ((rd_h == best_h_q) && (rd_r > best_r_q));

	assign out_free = !out_v_q || !point_stall;

	// memory ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// point to emit
	always_comb begin
		new_pt = '0;
		new_pt.heap_overflow = ovf_q;
		case (cmd.src)
			SRC_DROP: begin
				new_pt.point_x      = gone_r_q;
				new_pt.point_height = cur_q;
			end
			SRC_RISE: begin
				new_pt.point_x      = in_q.left_edge;
				new_pt.point_height = best_h_q;
			end
			SRC_OVF: begin
				new_pt.point_x      = in_q.left_edge;
				new_pt.point_height = cur_q;
			end
			default: begin
				new_pt.point_x      = in_q.left_edge;
				new_pt.point_height = cur_q;
			end
		endcase
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			in_q <= bldg;
		end
	end

	// scan for the top entry, one read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_v_s1  <= 1'b0;
			best_v_q <= 1'b0;
		end else if (cmd.scan_start) begin
			idx_q    <= '0;
			rd_v_s1  <= 1'b0;
			best_v_q <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_v_s1 <= idx_lt;
			if (idx_lt) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_v_s1 && (!best_v_q || rd_gt)) begin
				best_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			if (idx_lt) begin
				rd_i_s1 <= idx_q[IW-1:0];
			end
			if (rd_v_s1 && (!best_v_q || rd_gt)) begin
				best_h_q <= rd_h;
				best_r_q <= rd_r;
				best_i_q <= rd_i_s1;
			end
		end
		if (cmd.set_gone) begin
			gone_h_q <= best_h_q;
			gone_r_q <= best_r_q;
		end
	end

	// heap fill and skyline state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			cur_q     <= '0;
			ovf_q     <= 1'b0;
			emitted_q <= 1'b0;
		end else begin
			if (cmd.pop_wr) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.ins) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.cur_zero) begin
				cur_q <= '0;
			end else if (cmd.cur_best) begin
				cur_q <= best_h_q;
			end
			if (cmd.ld) begin
				ovf_q     <= 1'b0;
				emitted_q <= 1'b0;
			end else begin
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
				if (cmd.emit) begin
					emitted_q <= 1'b1;
				end
			end
		end
	end

	// one point held back so the last one can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= ((cmd.emit || cmd.fin) && pend_v_q) || (out_v_q && point_stall);
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.emit || cmd.fin) && pend_v_q) begin
			out_q <= {pend_q.point_x, pend_q.point_height, cmd.fin, pend_q.heap_overflow};
		end
		if (cmd.emit) begin
			pend_q <= new_pt;
		end
	end

	assign point_valid = out_v_q;
	assign point       = out_q;

	// status
	assign sts.flush        = (in_q.cmd == CMD_FLUSH);
	assign sts.count_zero   = (count_q == '0);
	assign sts.count_full   = (count_q == CW'(HEAP_DEPTH));
	assign sts.scan_done    = !idx_lt && !rd_v_s1;
	assign sts.best_lt_left = best_r_q < in_q.left_edge;
	assign sts.best_le_gone = best_r_q <= gone_r_q;
	assign sts.cur_lt_best  = cur_q < best_h_q;
	assign sts.cur_lt_gone  = cur_q < gone_h_q;
	assign sts.same_next    = in_q.next_same_left;
	assign sts.ovf          = ovf_q;
	assign sts.emitted      = emitted_q;
	assign sts.pend_v       = pend_v_q;
	assign sts.out_free     = out_free;

endmodule

[design/ssh_ctrl.sv]
module ssh_ctrl
	import ssh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     bldg_valid,
	output logic     bldg_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   can_emit;

	assign can_emit = !sts.pend_v || sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (bldg_valid) state_d = S_CHK;
			end
			S_CHK: begin
				if (!sts.count_zero) state_d = S_SCAN_A;
				else if (sts.flush) state_d = S_FIN;
				else state_d = S_INS;
			end
			S_SCAN_A: begin
				if (sts.scan_done) begin
					state_d = (sts.flush || sts.best_lt_left) ? S_POP_RD : S_INS;
				end
			end
			S_POP_RD: state_d = S_POP_WR;
			S_POP_WR: state_d = S_B_CHK;
			S_B_CHK: begin
				state_d = sts.count_zero ? S_DROP : S_SCAN_B;
			end
			S_SCAN_B: begin
				if (sts.scan_done) begin
					state_d = sts.best_le_gone ? S_POP_RD : S_DROP;
				end
			end
			S_DROP: begin
				if (!sts.cur_lt_gone || can_emit) state_d = S_CHK;
			end
			S_INS:    state_d = S_SCAN_C;
			S_SCAN_C: begin
				if (sts.scan_done) state_d = S_RISE;
			end
			S_RISE: begin
				if (!(sts.cur_lt_best && !sts.same_next) || can_emit) state_d = S_OVF;
			end
			S_OVF: begin
				if (!(sts.ovf && !sts.emitted) || can_emit) state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.pend_v || sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.src    = SRC_DROP;
		bldg_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.ld = bldg_valid;
			end
			S_CHK: begin
				cmd.scan_start = !sts.count_zero;
			end
			S_SCAN_A: begin
				cmd.scan_run = 1'b1;
				cmd.set_gone = sts.scan_done && (sts.flush || sts.best_lt_left);
			end
			S_POP_RD: cmd.pop_rd = 1'b1;
			S_POP_WR: cmd.pop_wr = 1'b1;
			S_B_CHK: begin
				cmd.cur_zero   = sts.count_zero;
				cmd.scan_start = !sts.count_zero;
			end
			S_SCAN_B: begin
				cmd.scan_run = 1'b1;
				cmd.cur_best = sts.scan_done && !sts.best_le_gone;
			end
			S_DROP: begin
				cmd.src  = SRC_DROP;
				cmd.emit = sts.cur_lt_gone && can_emit;
			end
			S_INS: begin
				cmd.ins        = !sts.count_full;
				cmd.set_ovf    = sts.count_full;
				cmd.scan_start = 1'b1;
			end
			S_SCAN_C: cmd.scan_run = 1'b1;
			S_RISE: begin
				cmd.src      = SRC_RISE;
				cmd.emit     = sts.cur_lt_best && !sts.same_next && can_emit;
				cmd.cur_best = cmd.emit;
			end
			S_OVF: begin
				cmd.src  = SRC_OVF;
				cmd.emit = sts.ovf && !sts.emitted && can_emit;
			end
			S_FIN: begin
				cmd.cur_zero = sts.flush;
				cmd.fin      = sts.pend_v && sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

[tb/tb_skyline_sweep_heap_core.sv]
`timescale 1ns / 1ps

module tb_skyline_sweep_heap_core;
	import ssh_pkg::*;

	localparam int DEPTH = HEAP_DEPTH_DEF;
	localparam logic [CoordW-1:0] XMAX = '1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      bldg_valid = 1'b0;
	logic      bldg_stall;
	in_item_t  bldg = '0;
	logic      point_valid;
	logic      point_stall = 1'b0;
	out_item_t point;

	skyline_sweep_heap_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.bldg_valid(bldg_valid),
		.bldg_stall(bldg_stall),
		.bldg(bldg),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the active building store
	logic [CoordW-1:0] act_h[DEPTH];
	logic [CoordW-1:0] act_r[DEPTH];
	int                act_cnt;
	logic [CoordW-1:0] sky_h;

	in_item_t  bldg_q[$];
	out_item_t points_due[$];
	out_item_t step_pts[$];
	int        n_errors = 0;
	int        n_accepted = 0;
	int        n_points = 0;
	int        n_ovf = 0;
	bit        stim_done = 0;

	function automatic int tallest();
		int best = 0;
		for (int i = 1; i < act_cnt; i++)
			if (act_h[i] > act_h[best] || (act_h[i] == act_h[best] && act_r[i] > act_r[best]))
				best = i;
		return best;
	endfunction

	function automatic void drop_tallest();
		int t;
		if (act_cnt == 0)
			return;
		t = tallest();
		act_cnt--;
		act_h[t] = act_h[act_cnt];
		act_r[t] = act_r[act_cnt];
	endfunction

	function automatic void add_point(logic [CoordW-1:0] x, logic [CoordW-1:0] h);
		out_item_t p;
		p.point_x = x;
		p.point_height = h;
		p.run_last = 1'b0;
		p.heap_overflow = 1'b0;
		step_pts.insert(step_pts.size(), p);
	endfunction

	// retire the top and every entry it covers; emit a drop point if lower
	function automatic void retire_tallest();
		int t = tallest();
		logic [CoordW-1:0] gone_h = act_h[t];
		logic [CoordW-1:0] gone_r = act_r[t];
		drop_tallest();
		while (act_cnt > 0 && act_r[tallest()] <= gone_r)
			drop_tallest();
		sky_h = (act_cnt > 0) ? act_h[tallest()] : '0;
		if (sky_h < gone_h)
			add_point(gone_r, sky_h);
	endfunction

	// expected key points for one accepted item
	function automatic void predict_points(in_item_t it);
		bit ovf = 0;
		step_pts.delete();
		if (it.cmd == CMD_FLUSH) begin
			while (act_cnt > 0)
				retire_tallest();
			sky_h = '0;
		end else begin
			while (act_cnt > 0 && act_r[tallest()] < it.left_edge)
				retire_tallest();
			if (act_cnt < DEPTH) begin
				act_h[act_cnt] = it.bldg_height;
				act_r[act_cnt] = it.right_edge;
				act_cnt++;
			end else
				ovf = 1;
			if (act_cnt > 0 && sky_h < act_h[tallest()] && !it.next_same_left) begin
				sky_h = act_h[tallest()];
				add_point(it.left_edge, sky_h);
			end
			if (ovf && step_pts.size() == 0)
				add_point(it.left_edge, sky_h);
		end
		foreach (step_pts[k]) begin
			step_pts[k].heap_overflow = ovf;
			step_pts[k].run_last = (k == step_pts.size() - 1);
			points_due.insert(points_due.size(), step_pts[k]);
		end
		if (ovf)
			n_ovf++;
	endfunction

	task automatic put_bldg(int unsigned l, int unsigned r, int unsigned h, bit same);
		in_item_t it;
		it.cmd = CMD_BLDG;
		it.left_edge = l[CoordW-1:0];
		it.right_edge = r[CoordW-1:0];
		it.bldg_height = h[CoordW-1:0];
		it.next_same_left = same;
		bldg_q.insert(bldg_q.size(), it);
	endtask

	task automatic put_flush();
		in_item_t it;
		logic [95:0] rnd;
		rnd = {$urandom, $urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.cmd = CMD_FLUSH;
		bldg_q.insert(bldg_q.size(), it);
	endtask

	// one skyline of n buildings, sorted by left edge
	task automatic put_skyline(int n, bit wide, bit tall_ends);
		int unsigned ls[$];
		int unsigned l, r, h, w;
		bit same;
		for (int i = 0; i < n; i++)
			ls.insert(ls.size(), wide ? ($urandom & XMAX) : $urandom_range(0, 4 * n + 4));
		if ($urandom_range(0, 3) == 0 && n > 1)
			ls[1] = ls[0];
		ls.sort();
		for (int i = 0; i < n; i++) begin
			l = ls[i];
			w = wide ? ($urandom & XMAX) : $urandom_range(0, 12);
			r = (tall_ends || l + w > XMAX || l + w < l) ? XMAX - $urandom_range(0, 3) : l + w;
			if ($urandom_range(0, 19) == 0)
				r = $urandom_range(0, l);
			h = wide ? ($urandom & XMAX) : $urandom_range(0, 15);
			same = (i + 1 < n) ? (ls[i + 1] == l) : 1'b0;
			if ($urandom_range(0, 15) == 0)
				same = ~same;
			put_bldg(l, r, h, same);
		end
	endtask

	// stimulus
	initial begin
		act_cnt = 0;
		sky_h = '0;
		put_flush();
		put_bldg(0, XMAX, XMAX, 0);
		put_bldg(XMAX, XMAX, 0, 1);
		put_bldg(XMAX, XMAX, 7, 0);
		put_flush();
		put_bldg(5, 9, 3, 1);
		put_bldg(5, 7, 8, 0);
		put_bldg(6, 2, 4, 0);
		put_bldg(8, 12, 8, 0);
		put_bldg(10, 11, 0, 0);
		put_bldg(13, 20, 2, 0);
		put_bldg(30, 31, 5, 0);
		put_flush();
		put_bldg(2, 9, 10, 0);
		put_bldg(3, 7, 15, 0);
		put_bldg(5, 12, 12, 0);
		put_bldg(15, 20, 10, 0);
		put_bldg(19, 24, 8, 0);
		put_flush();
		while (bldg_q.size() < 460) begin
			case ($urandom_range(0, 9))
				0: put_skyline(DEPTH + $urandom_range(1, 3), 0, 1);
				1, 2: put_skyline($urandom_range(1, 10), 1, 0);
				default: put_skyline($urandom_range(1, 12), 0, 0);
			endcase
			if ($urandom_range(0, 7) != 0)
				put_flush();
		end
		put_flush();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender: bursts of items with random gaps
	bit took = 0;
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			bldg_valid <= 1'b0;
		end else if (bldg_valid && !took) begin
			// hold the stalled item
		end else if (gap_left > 0) begin
			gap_left--;
			bldg_valid <= 1'b0;
		end else if (bldg_q.size() > 0) begin
			bldg <= bldg_q.pop_front();
			bldg_valid <= 1'b1;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 20);
			end else
				burst_left--;
		end else begin
			bldg_valid <= 1'b0;
			stim_done = 1;
		end
		took = 0;
	end

	// receiver: stall pattern re-picked at random periodically, one long hold-off
	int cyc = 0;
	int stall_mode = 0;
	int hold_left = 0;
	bit held = 0;
	always @(negedge clk) begin
		cyc++;
		if (cyc % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		if (!held && n_accepted >= 150) begin
			held = 1;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			point_stall <= 1'b1;
		end else case (stall_mode)
			0: point_stall <= 1'b0;
			1: point_stall <= ($urandom_range(0, 9) < 3);
			2: point_stall <= ($urandom_range(0, 9) < 8);
			default: point_stall <= (cyc % 5 == 0);
		endcase
	end

	// accept items and check points
	out_item_t want;
	always @(posedge clk) begin
		if (arst_n && bldg_valid && !bldg_stall) begin
			took = 1;
			n_accepted++;
			predict_points(bldg);
		end
		if (arst_n && point_valid && !point_stall) begin
			n_points++;
			if (points_due.size() == 0) begin
				$error("unexpected point x=%0d h=%0d", point.point_x, point.point_height);
				n_errors++;
			end else begin
				want = points_due.pop_front();
				if (point.point_x !== want.point_x) begin
					$error("point_x expected %0d got %0d", want.point_x, point.point_x);
					n_errors++;
				end
				if (point.point_height !== want.point_height) begin
					$error("point_height expected %0d got %0d", want.point_height,
						point.point_height);
					n_errors++;
				end
				if (point.run_last !== want.run_last) begin
					$error("run_last expected %0b got %0b", want.run_last, point.run_last);
					n_errors++;
				end
				if (point.heap_overflow !== want.heap_overflow) begin
					$error("heap_overflow expected %0b got %0b", want.heap_overflow,
						point.heap_overflow);
					n_errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (points_due.size() == 0);
		repeat (500) @(posedge clk);
		if (points_due.size() != 0) begin
			$error("%0d points never arrived", points_due.size());
			n_errors++;
		end
		$display("Swept %0d items (%0d full-store drops), checked %0d key points.",
			n_accepted, n_ovf, n_points);
		if (n_errors == 0)
			$display("skyline_sweep_heap_core test passed");
		else
			$display("skyline_sweep_heap_core test failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("skyline_sweep_heap_core test failed");
		$finish;
	end

endmodule
